// ===== rtl/tst_pkg.sv =====
// Shared constants, codes and types of the touch slot tap tracker.
package tst_pkg;

	localparam int SLOTS = 4;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ACT_W = (SLOTS > 4) ? SLOTS : 4;

	localparam int PIX_W = 12;
	localparam int NORM_W = 16;
	localparam int ID_W = 64;
	localparam int MASK_W = 4;
	localparam int REG_IDX_W = 3;

	localparam logic [PIX_W-1:0] RST_SCREEN_WIDTH = 12'd272;
	localparam logic [PIX_W-1:0] RST_SCREEN_HEIGHT = 12'd480;
	localparam logic [PIX_W-1:0] RST_WINDOW_LEFT = 12'd8;
	localparam logic [PIX_W-1:0] RST_WINDOW_TOP = 12'd8;
	localparam logic [PIX_W-1:0] RST_WINDOW_SIZE = 12'd256;

	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEFT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_TOP = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd4;

	localparam logic ACT_REPORT = 1'b0;
	localparam logic ACT_FRAME_END = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE_X,
		ST_SCALE_Y,
		ST_CAPT_Y,
		ST_MATCH,
		ST_EOF_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] size;
	} window_t;

endpackage

// ===== rtl/tst_rpt_if.sv =====
// Input channel: finger reports and end-of-frame words.
interface tst_rpt_if;
	import tst_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [ID_W-1:0]   finger_id;
	logic [NORM_W-1:0] norm_x;
	logic [NORM_W-1:0] norm_y;

	modport source (output valid, action, finger_id, norm_x, norm_y, input ready);
	modport sink (input valid, action, finger_id, norm_x, norm_y, output ready);
endinterface

// ===== rtl/tst_res_if.sv =====
// Output channel: per-frame tap result words.
interface tst_res_if;
	import tst_pkg::*;

	logic              valid;
	logic              ready;
	logic              tap;
	logic [MASK_W-1:0] active_slots;

	modport source (output valid, tap, active_slots, input ready);
	modport sink (input valid, tap, active_slots, output ready);
endinterface

// ===== rtl/tst_mul_unit.sv =====
// Shared scaler: pixel = floor(norm * size / 65536), registered result.
module tst_mul_unit
	import tst_pkg::*;
(
	input  logic              clk,
	input  logic [NORM_W-1:0] norm,
	input  logic [PIX_W-1:0]  size,
	output logic [PIX_W-1:0]  pix
);

	logic [NORM_W+PIX_W-1:0] prod;

	assign prod = norm * size;

	always_ff @(posedge clk) begin
		pix <= prod[NORM_W+PIX_W-1:NORM_W];
	end

endmodule

// ===== rtl/tst_win_unit.sv =====
// Shared window compare: left <= p < left + size on both axes, no wrap.
module tst_win_unit
	import tst_pkg::*;
(
	input  window_t          win,
	input  logic [PIX_W-1:0] px,
	input  logic [PIX_W-1:0] py,
	output logic             in_win
);

	logic [PIX_W:0] x_end;
	logic [PIX_W:0] y_end;

	assign x_end = {1'b0, win.left} + {1'b0, win.size};
	assign y_end = {1'b0, win.top} + {1'b0, win.size};

	assign in_win = (px >= win.left) && ({1'b0, px} < x_end) &&
			(py >= win.top) && ({1'b0, py} < y_end);

endmodule

// ===== rtl/touch_slot_tap_tracker_unit.sv =====
// Touch slot tap tracker. A finger report is accepted only when rpt.ready is high; it
// then passes the shared scaler (x, then y, then capture) and scans the slots one per
// cycle for an id match or the first free slot, and the block is ready again once a
// slot matches or the last slot is scanned; reports past the first SLOTS of a frame
// are dropped at once. An end-of-frame word scans the slots one per cycle through the
// window compare unit, then loads the result register, giving one word with tap and the
// active mask of slots 0 to 3; it waits there only if the previous word is still held.
module touch_slot_tap_tracker_unit
	import tst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data,
	tst_rpt_if.sink              rpt,
	tst_res_if.source            res
);

	// configuration
	logic [PIX_W-1:0] screen_width_q;
	logic [PIX_W-1:0] screen_height_q;
	window_t          win_q;

	// slot store
	logic [SLOTS-1:0] active_q;
	logic [SLOTS-1:0] seen_q;
	logic [SLOTS-1:0] began_q;
	logic [ID_W-1:0]  finger_q [SLOTS];
	logic [PIX_W-1:0] last_x_q [SLOTS];
	logic [PIX_W-1:0] last_y_q [SLOTS];

	// sequencer
	state_t            state_q;
	state_t            state_d;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  count_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic              tap_q;

	// current word
	logic [ID_W-1:0]   id_q;
	logic [NORM_W-1:0] nx_q;
	logic [NORM_W-1:0] ny_q;
	logic [PIX_W-1:0]  px_q;
	logic [PIX_W-1:0]  py_q;

	// result register
	logic              res_valid_q;
	logic              res_tap_q;
	logic [MASK_W-1:0] res_mask_q;

	logic              rpt_acc;
	logic              take_rpt;
	logic              match_hit;
	logic              last_idx;
	logic              free_now;
	logic              alloc_ok;
	logic [SLOT_W-1:0] alloc_idx;
	logic              res_load;
	logic [NORM_W-1:0] mul_norm;
	logic [PIX_W-1:0]  mul_size;
	logic [PIX_W-1:0]  mul_pix;
	logic [PIX_W-1:0]  win_px;
	logic [PIX_W-1:0]  win_py;
	logic              in_win;
	logic [ACT_W-1:0]  act_pad;

	tst_mul_unit u_mul (
		.clk  (clk),
		.norm (mul_norm),
		.size (mul_size),
		.pix  (mul_pix)
	);

	tst_win_unit u_win (
		.win    (win_q),
		.px     (win_px),
		.py     (win_py),
		.in_win (in_win)
	);

	assign rpt.ready = (state_q == ST_IDLE);
	assign rpt_acc = rpt.valid && rpt.ready;
	assign take_rpt = (rpt.action == ACT_REPORT) && (count_q < CNT_W'(SLOTS));

	assign match_hit = active_q[idx_q] && (finger_q[idx_q] == id_q);
	assign last_idx = (idx_q == SLOT_W'(SLOTS - 1));
	assign free_now = !active_q[idx_q];
	assign alloc_ok = free_found_q || free_now;
	assign alloc_idx = free_found_q ? free_idx_q : idx_q;
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	assign mul_norm = (state_q == ST_SCALE_X) ? nx_q : ny_q;
	assign mul_size = (state_q == ST_SCALE_X) ? screen_width_q : screen_height_q;
	assign win_px = (state_q == ST_EOF_SCAN) ? last_x_q[idx_q] : px_q;
	assign win_py = (state_q == ST_EOF_SCAN) ? last_y_q[idx_q] : py_q;

	assign act_pad = ACT_W'(active_q);

	assign res.valid = res_valid_q;
	assign res.tap = res_tap_q;
	assign res.active_slots = res_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (rpt_acc) begin
					if (rpt.action == ACT_FRAME_END) begin
						state_d = ST_EOF_SCAN;
					end else if (take_rpt) begin
						state_d = ST_SCALE_X;
					end
				end
			end
			ST_SCALE_X: state_d = ST_SCALE_Y;
			ST_SCALE_Y: state_d = ST_CAPT_Y;
			ST_CAPT_Y:  state_d = ST_MATCH;
			ST_MATCH: begin
				if (match_hit || last_idx) begin
					state_d = ST_IDLE;
				end
			end
			ST_EOF_SCAN: begin
				if (last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			win_q.left <= RST_WINDOW_LEFT;
			win_q.top <= RST_WINDOW_TOP;
			win_q.size <= RST_WINDOW_SIZE;
			active_q <= '0;
			seen_q <= '0;
			idx_q <= '0;
			count_q <= '0;
			free_found_q <= 1'b0;
			tap_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  screen_width_q <= cfg_data;
					REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
					REG_WINDOW_LEFT:   win_q.left <= cfg_data;
					REG_WINDOW_TOP:    win_q.top <= cfg_data;
					REG_WINDOW_SIZE:   win_q.size <= cfg_data;
					default: ;
				endcase
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					free_found_q <= 1'b0;
					tap_q <= 1'b0;
					if (rpt_acc && take_rpt) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_MATCH: begin
					if (!free_found_q && free_now) begin
						free_found_q <= 1'b1;
					end
					if (match_hit) begin
						seen_q[idx_q] <= 1'b1;
					end else if (last_idx && alloc_ok) begin
						active_q[alloc_idx] <= 1'b1;
						seen_q[alloc_idx] <= 1'b1;
					end
					idx_q <= idx_q + SLOT_W'(1);
				end
				ST_EOF_SCAN: begin
					// unseen fingers lifted this frame
					if (active_q[idx_q] && !seen_q[idx_q]) begin
						if (began_q[idx_q] && in_win) begin
							tap_q <= 1'b1;
						end
						active_q[idx_q] <= 1'b0;
					end
					seen_q[idx_q] <= 1'b0;
					idx_q <= idx_q + SLOT_W'(1);
					if (last_idx) begin
						count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (rpt_acc) begin
					id_q <= rpt.finger_id;
					nx_q <= rpt.norm_x;
					ny_q <= rpt.norm_y;
				end
			end
			ST_SCALE_Y: px_q <= mul_pix;
			ST_CAPT_Y:  py_q <= mul_pix;
			ST_MATCH: begin
				if (!free_found_q && free_now) begin
					free_idx_q <= idx_q;
				end
				if (match_hit) begin
					last_x_q[idx_q] <= px_q;
					last_y_q[idx_q] <= py_q;
				end else if (last_idx && alloc_ok) begin
					finger_q[alloc_idx] <= id_q;
					began_q[alloc_idx] <= in_win;
					last_x_q[alloc_idx] <= px_q;
					last_y_q[alloc_idx] <= py_q;
				end
			end
			ST_DONE: begin
				if (res_load) begin
					res_tap_q <= tap_q;
					res_mask_q <= act_pad[MASK_W-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule
